// ===== src/tsd_pkg.sv =====
`default_nettype none

package tsd_pkg;

    // parse phase of the body stream
    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2,
        PH_DRAIN = 2'd3
    } phase_t;

    // completion status carried with each result
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SEQ   = 2'd1,
        ST_NEG   = 2'd2,
        ST_TRUNC = 2'd3
    } status_t;

    typedef struct packed {
        logic [6:0] field_number;
        logic [7:0] value_byte;
        logic       byte_kept;
        logic       field_done;
        logic       message_done;
        status_t    status;
    } result_t;

    localparam logic [7:0] FIRST_TYPE    = 8'd1;
    localparam logic [1:0] LEN_COUNT_LAST = 2'd3;

endpackage

`default_nettype wire

// ===== src/tsd_if.sv =====
`default_nettype none

interface tsd_body_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       body_last;

    modport source (output valid, output body_byte, output body_last, input ready);
    modport sink   (input valid, input body_byte, input body_last, output ready);
endinterface

interface tsd_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] field_number;
    logic [7:0] value_byte;
    logic       byte_kept;
    logic       field_done;
    logic       message_done;
    logic [1:0] status;

    modport source (
        output valid, output field_number, output value_byte, output byte_kept,
        output field_done, output message_done, output status, input ready
    );
    modport sink (
        input valid, input field_number, input value_byte, input byte_kept,
        input field_done, input message_done, input status, output ready
    );
endinterface

`default_nettype wire

// ===== src/tsd_parser.sv =====
`default_nettype none

module tsd_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_valid,
    input  wire logic [7:0]      step_byte,
    input  wire logic            step_last,
    output logic                 has_result,
    output tsd_pkg::result_t     result
);

    tsd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  expected_type_reg, expected_type_next;
    logic [1:0]  length_byte_count_reg, length_byte_count_next;
    logic [23:0] length_accum_reg, length_accum_next;
    logic [30:0] bytes_remaining_reg, bytes_remaining_next;
    logic        zero_seen_reg, zero_seen_next;

    logic        type_mismatch;
    logic [31:0] accum_full;
    logic        len_final;
    logic        zero_new;
    logic [30:0] remaining_dec;
    logic        value_done;
    logic        restart;
    logic [6:0]  cur_type;

    assign type_mismatch = step_byte[7] || (step_byte != expected_type_reg);
    assign accum_full    = {length_accum_reg, step_byte};
    assign len_final     = (length_byte_count_reg == tsd_pkg::LEN_COUNT_LAST);
    assign zero_new      = zero_seen_reg || (step_byte == 8'd0);
    assign remaining_dec = bytes_remaining_reg - 31'd1;
    assign value_done    = (remaining_dec == 31'd0);
    assign cur_type      = expected_type_reg[6:0];

    // next state
    always_comb
    begin
        phase_next             = phase_reg;
        expected_type_next     = expected_type_reg;
        length_byte_count_next = length_byte_count_reg;
        length_accum_next      = length_accum_reg;
        bytes_remaining_next   = bytes_remaining_reg;
        zero_seen_next         = zero_seen_reg;
        restart                = 1'b0;
        if (step_valid)
        begin
            unique case (phase_reg)
                tsd_pkg::PH_TYPE:
                begin
                    if (type_mismatch)
                    begin
                        phase_next = tsd_pkg::PH_DRAIN;
                    end
                    else
                    begin
                        phase_next             = tsd_pkg::PH_LEN;
                        length_byte_count_next = 2'd0;
                        length_accum_next      = 24'd0;
                    end
                    restart = step_last;
                end
                tsd_pkg::PH_LEN:
                begin
                    length_accum_next = accum_full[23:0];
                    if (!len_final)
                    begin
                        length_byte_count_next = length_byte_count_reg + 2'd1;
                    end
                    else
                    begin
                        length_byte_count_next = 2'd0;
                        if (accum_full[31])
                        begin
                            phase_next = tsd_pkg::PH_DRAIN;
                        end
                        else if (accum_full == 32'd0)
                        begin
                            expected_type_next = expected_type_reg + 8'd1;
                            phase_next         = tsd_pkg::PH_TYPE;
                        end
                        else
                        begin
                            bytes_remaining_next = accum_full[30:0];
                            zero_seen_next       = 1'b0;
                            phase_next           = tsd_pkg::PH_VALUE;
                        end
                    end
                    restart = step_last;
                end
                tsd_pkg::PH_VALUE:
                begin
                    bytes_remaining_next = remaining_dec;
                    zero_seen_next       = zero_new;
                    if (value_done)
                    begin
                        expected_type_next = expected_type_reg + 8'd1;
                        phase_next         = tsd_pkg::PH_TYPE;
                        zero_seen_next     = 1'b0;
                    end
                    restart = step_last;
                end
                tsd_pkg::PH_DRAIN:
                begin
                    restart = step_last;
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase
        end
        // end of message: back to the reset state
        if (restart)
        begin
            phase_next             = tsd_pkg::PH_TYPE;
            expected_type_next     = tsd_pkg::FIRST_TYPE;
            length_byte_count_next = 2'd0;
            length_accum_next      = 24'd0;
            bytes_remaining_next   = 31'd0;
            zero_seen_next         = 1'b0;
        end
    end

    // result
    always_comb
    begin
        has_result          = 1'b0;
        result.field_number = cur_type;
        result.value_byte   = 8'd0;
        result.byte_kept    = 1'b0;
        result.field_done   = 1'b0;
        result.message_done = 1'b1;
        result.status       = tsd_pkg::ST_OK;
        if (step_valid)
        begin
            unique case (phase_reg)
                tsd_pkg::PH_TYPE:
                begin
                    if (type_mismatch)
                    begin
                        has_result          = 1'b1;
                        result.field_number = 7'd0;
                        result.status       = tsd_pkg::ST_SEQ;
                    end
                    else
                    begin
                        has_result    = step_last;
                        result.status = tsd_pkg::ST_TRUNC;
                    end
                end
                tsd_pkg::PH_LEN:
                begin
                    if (!len_final)
                    begin
                        has_result    = step_last;
                        result.status = tsd_pkg::ST_TRUNC;
                    end
                    else if (accum_full[31])
                    begin
                        has_result    = 1'b1;
                        result.status = tsd_pkg::ST_NEG;
                    end
                    else if (accum_full == 32'd0)
                    begin
                        has_result          = 1'b1;
                        result.field_done   = 1'b1;
                        result.message_done = step_last;
                    end
                    else
                    begin
                        has_result    = step_last;
                        result.status = tsd_pkg::ST_TRUNC;
                    end
                end
                tsd_pkg::PH_VALUE:
                begin
                    has_result          = 1'b1;
                    result.value_byte   = step_byte;
                    result.byte_kept    = !zero_new;
                    result.field_done   = value_done;
                    result.message_done = step_last;
                    result.status       = (step_last && !value_done) ? tsd_pkg::ST_TRUNC
                                                                     : tsd_pkg::ST_OK;
                end
                tsd_pkg::PH_DRAIN:
                begin
                    has_result = 1'b0;
                end
                default:
                begin
                    has_result = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= tsd_pkg::PH_TYPE;
            expected_type_reg     <= tsd_pkg::FIRST_TYPE;
            length_byte_count_reg <= 2'd0;
            length_accum_reg      <= 24'd0;
            bytes_remaining_reg   <= 31'd0;
            zero_seen_reg         <= 1'b0;
        end
        else
        begin
            phase_reg             <= phase_next;
            expected_type_reg     <= expected_type_next;
            length_byte_count_reg <= length_byte_count_next;
            length_accum_reg      <= length_accum_next;
            bytes_remaining_reg   <= bytes_remaining_next;
            zero_seen_reg         <= zero_seen_next;
        end
    end

    // a closed message that ended cleanly or truncated restarts the sequence
    a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step_valid && has_result && result.message_done
         && (result.status == tsd_pkg::ST_OK || result.status == tsd_pkg::ST_TRUNC))
        |=> (phase_reg == tsd_pkg::PH_TYPE && expected_type_reg == tsd_pkg::FIRST_TYPE))
        else $error("deframer did not restart after message end");

    // a field closed mid-message advances the expected type by one
    a_type_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (step_valid && has_result && result.field_done && !result.message_done)
        |=> (phase_reg == tsd_pkg::PH_TYPE
             && expected_type_reg == $past(expected_type_reg) + 8'd1))
        else $error("expected type did not advance after a closed field");

    // an error before the last byte drops the rest of the body
    a_error_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (step_valid && !step_last && has_result
         && (result.status == tsd_pkg::ST_SEQ || result.status == tsd_pkg::ST_NEG))
        |=> (phase_reg == tsd_pkg::PH_DRAIN))
        else $error("error did not lead to drain");

endmodule

`default_nettype wire

// ===== src/tsd_result_fifo.sv =====
`default_nettype none

module tsd_result_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  tsd_pkg::result_t      push_data,
    output logic                  has_space,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output tsd_pkg::result_t      out_data
);

    tsd_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign has_space = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2 || pop))
        else $error("result buffer overflow");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("result buffer count mismatch");

endmodule

`default_nettype wire

// ===== src/tlv_sequence_deframer.sv =====
`default_nettype none

// tlv sequence deframer
//
// body channel (sink): one body byte per transaction, body_last on the final
// byte. the body is a series of fields: type byte, 4-byte big-endian length,
// then that many value bytes. type bytes must count up from 1.
// result channel (source): at most one transaction per body byte. value bytes
// come out one per transaction with field_number, byte_kept (clear from the
// first zero byte of a field on), field_done and message_done; errors and
// truncation show up in status with message_done set.
// a body byte is held in the input register, parsed from there, and its result
// is written into the result buffer, from which it is offered.
// throughput: one body byte per cycle while the two-entry result buffer has
// space, set by the combinational parse step between input register and buffer.
// after an error, bytes are dropped without results until body_last.
// reset: state returns to expecting type 1, both channels empty.
// a stalled receiver fills the result buffer; the body channel then holds off
// once the buffer and the input register are both occupied.
module tlv_sequence_deframer (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tsd_body_if.sink      body,
    tsd_result_if.source  result
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic             advance;
    logic             fifo_space;
    logic             step_has_result;
    tsd_pkg::result_t step_result;
    tsd_pkg::result_t out_data;

    // the parse step fires when the buffer can take its result
    assign advance    = in_valid_reg && fifo_space;
    assign body.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (body.valid && body.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (body.valid && body.ready)
        begin
            in_byte_reg <= body.body_byte;
            in_last_reg <= body.body_last;
        end
    end

    tsd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (advance),
        .step_byte  (in_byte_reg),
        .step_last  (in_last_reg),
        .has_result (step_has_result),
        .result     (step_result)
    );

    tsd_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && step_has_result),
        .push_data (step_result),
        .has_space (fifo_space),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    assign result.field_number = out_data.field_number;
    assign result.value_byte   = out_data.value_byte;
    assign result.byte_kept    = out_data.byte_kept;
    assign result.field_done   = out_data.field_done;
    assign result.message_done = out_data.message_done;
    assign result.status       = out_data.status;

endmodule

`default_nettype wire

// ===== test/tlv_sequence_deframer_checker.sv =====
module tlv_sequence_deframer_checker (
    input  logic  clk,
    input  logic  rst_n,
    tsd_body_if   body,
    tsd_result_if result,
    output int    error_count,
    output int    backlog
);
    import tsd_pkg::*;

    // parser state mirrored at the block's widths, but len_acc keeps all 32 length bits
    phase_t      ph;
    logic [7:0]  want_type;
    logic [1:0]  len_count;
    logic [31:0] len_acc;
    logic [30:0] remaining;
    logic        zero_seen;

    result_t deframed_q[$];
    int      mismatches = 0;

    assign error_count = mismatches;

    task automatic restart_message();
        ph        = PH_TYPE;
        want_type = FIRST_TYPE;
        len_count = '0;
        len_acc   = '0;
        remaining = '0;
        zero_seen = 1'b0;
    endtask

    // append one predicted result at the tail
    task automatic queue_result(input result_t r);
        deframed_q = {deframed_q, r};
    endtask

    // one body byte in, zero or one deframed result out
    task automatic deframe_byte(input logic [7:0] b, input logic last);
        result_t     r;
        logic [7:0]  cur;
        logic [31:0] acc;
        logic        done;
        cur = want_type;
        r   = '0;
        case (ph)
            PH_TYPE:
            begin
                if (b != want_type || b[7])
                begin
                    r.message_done = 1'b1;
                    r.status       = ST_SEQ;
                    queue_result(r);
                    if (last)
                        restart_message();
                    else
                        ph = PH_DRAIN;
                end
                else
                begin
                    ph        = PH_LEN;
                    len_count = '0;
                    len_acc   = '0;
                    if (last)
                    begin
                        r.field_number = cur[6:0];
                        r.message_done = 1'b1;
                        r.status       = ST_TRUNC;
                        queue_result(r);
                        restart_message();
                    end
                end
            end
            PH_LEN:
            begin
                acc     = {len_acc[23:0], b};
                len_acc = acc;
                r.field_number = cur[6:0];
                if (len_count != LEN_COUNT_LAST)
                begin
                    len_count = len_count + 2'd1;
                    if (last)
                    begin
                        r.message_done = 1'b1;
                        r.status       = ST_TRUNC;
                        queue_result(r);
                        restart_message();
                    end
                end
                else
                begin
                    len_count = '0;
                    if (acc[31])
                    begin
                        r.message_done = 1'b1;
                        r.status       = ST_NEG;
                        queue_result(r);
                        if (last)
                            restart_message();
                        else
                            ph = PH_DRAIN;
                    end
                    else if (acc == 32'd0)
                    begin
                        r.field_done   = 1'b1;
                        r.message_done = last;
                        r.status       = ST_OK;
                        queue_result(r);
                        if (last)
                            restart_message();
                        else
                        begin
                            want_type = cur + 8'd1;
                            ph        = PH_TYPE;
                        end
                    end
                    else
                    begin
                        remaining = acc[30:0];
                        zero_seen = 1'b0;
                        ph        = PH_VALUE;
                        if (last)
                        begin
                            r.message_done = 1'b1;
                            r.status       = ST_TRUNC;
                            queue_result(r);
                            restart_message();
                        end
                    end
                end
            end
            PH_VALUE:
            begin
                if (b == 8'd0)
                    zero_seen = 1'b1;
                remaining      = remaining - 31'd1;
                done           = (remaining == 31'd0);
                r.field_number = cur[6:0];
                r.value_byte   = b;
                r.byte_kept    = ~zero_seen;
                r.field_done   = done;
                r.message_done = last;
                r.status       = (last && !done) ? ST_TRUNC : ST_OK;
                queue_result(r);
                if (last)
                    restart_message();
                else if (done)
                begin
                    want_type = cur + 8'd1;
                    ph        = PH_TYPE;
                    zero_seen = 1'b0;
                end
            end
            default:
            begin
                if (last)
                    restart_message();
            end
        endcase
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    task automatic compare_result();
        result_t want;
        if (deframed_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual field %0d byte %0d status %0d",
                     $time, result.field_number, result.value_byte, result.status);
        end
        else
        begin
            want = deframed_q.pop_front();
            check_field("field_number", want.field_number, result.field_number);
            check_field("value_byte", want.value_byte, result.value_byte);
            check_field("byte_kept", want.byte_kept, result.byte_kept);
            check_field("field_done", want.field_done, result.field_done);
            check_field("message_done", want.message_done, result.message_done);
            check_field("status", want.status, result.status);
        end
    endtask

    // results pass the input register and the result buffer after their byte, so order here is free
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            deframed_q.delete();
        end
        else
        begin
            if (result.valid && result.ready)
                compare_result();
            if (body.valid && body.ready)
                deframe_byte(body.body_byte, body.body_last);
        end
        backlog = deframed_q.size();
    end

endmodule

// ===== test/tlv_sequence_deframer_tb.sv =====
module tlv_sequence_deframer_tb;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n;

    always #6 clk = ~clk;

    tsd_body_if   body_ch ();
    tsd_result_if result_ch ();

    tlv_sequence_deframer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body_ch),
        .result (result_ch)
    );

    int error_count;
    int backlog;

    tlv_sequence_deframer_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .body        (body_ch),
        .result      (result_ch),
        .error_count (error_count),
        .backlog     (backlog)
    );

    // stimulus bookkeeping
    logic [7:0] msg[$];       // body bytes of the message being built
    int         sent_count = 0;
    logic       calm = 1'b0;  // no idling on either side once set
    logic       hold_results = 1'b0;

    // push one body byte through the handshake, then maybe go idle
    task automatic send_byte(input logic [7:0] b, input logic last);
        body_ch.valid     <= 1'b1;
        body_ch.body_byte <= b;
        body_ch.body_last <= last;
        do
            @(posedge clk);
        while (!body_ch.ready);
        sent_count++;
        // long receiver hold-off while bytes keep coming
        if (sent_count == 500)
            hold_results = 1'b1;
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            body_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // whole message out, last flag on its final byte
    task automatic send_msg();
        for (int i = 0; i < msg.size(); i++)
            send_byte(msg[i], i == msg.size() - 1);
        msg.delete();
    endtask

    // one more byte at the end of the message being built
    task automatic append_byte(input logic [7:0] b);
        msg = {msg, b};
    endtask

    // type byte, big-endian length, then nvals value bytes (zeros now and then)
    task automatic add_field(input logic [7:0] ftype, input logic [31:0] flen,
                             input int nvals);
        append_byte(ftype);
        append_byte(flen[31:24]);
        append_byte(flen[23:16]);
        append_byte(flen[15:8]);
        append_byte(flen[7:0]);
        repeat (nvals)
            append_byte(($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
    endtask

    // well-formed fields numbered 1..nf, mostly short
    task automatic add_good_fields(input int nf);
        int sel;
        int len;
        for (int k = 1; k <= nf; k++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 2)
                len = 0;
            else if (sel < 9)
                len = $urandom_range(1, 6);
            else
                len = $urandom_range(7, 40);
            add_field(8'(k), 32'(len), len);
        end
    endtask

    // receiver side: random stall bursts, one long hold-off on request
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                hold_results = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #(12 * 300000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int         pick;
        int         nf;
        int         cut;
        logic [7:0] wrong;
        logic       overflow_done;

        overflow_done = 1'b0;
        rst_n             <= 1'b0;
        body_ch.valid     <= 1'b0;
        body_ch.body_byte <= 8'd0;
        body_ch.body_last <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero length field closing the message
        add_field(8'd1, 32'd0, 0);
        send_msg();
        // wrong type on a last byte
        append_byte(8'd2);
        send_msg();
        // type byte 255, then a dropped byte until last
        append_byte(8'hFF);
        append_byte(8'd1);
        send_msg();
        // all-ones length is negative
        add_field(8'd1, 32'hFFFF_FFFF, 0);
        send_msg();
        // zero value byte, message cut mid-field
        add_field(8'd1, 32'd3, 0);
        append_byte(8'd0);
        send_msg();
        // last flag on a matching type byte
        append_byte(8'd1);
        send_msg();
        // last flag on the first length byte
        append_byte(8'd1);
        append_byte(8'd0);
        send_msg();
        // one value byte of 255 closes field and message
        add_field(8'd1, 32'd1, 0);
        append_byte(8'hFF);
        send_msg();
        // largest positive length, cut right after it
        add_field(8'd1, 32'h7FFF_FFFF, 0);
        send_msg();

        // random messages, mostly well formed
        while (sent_count < 1240)
        begin
            if (sent_count >= 1080)
                calm = 1'b1;
            if (!overflow_done && sent_count >= 650)
            begin
                // run past field 127, type 128 can never match
                overflow_done = 1'b1;
                for (int k = 1; k <= 127; k++)
                    add_field(8'(k), 32'd0, 0);
                append_byte(8'd128);
                repeat ($urandom_range(0, 2))
                    append_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    add_good_fields($urandom_range(1, 4));
                else if (pick < 76)
                begin
                    // good message chopped anywhere
                    add_good_fields($urandom_range(1, 3));
                    cut = $urandom_range(1, msg.size() - 1);
                    repeat (cut)
                        void'(msg.pop_back());
                end
                else if (pick < 81)
                begin
                    // huge positive length, only a few value bytes
                    nf = $urandom_range(0, 2);
                    add_good_fields(nf);
                    add_field(8'(nf + 1), {1'b0, 31'($urandom())}, $urandom_range(0, 3));
                end
                else if (pick < 88)
                begin
                    // field out of sequence, then junk to drop
                    nf = $urandom_range(0, 2);
                    add_good_fields(nf);
                    wrong = 8'($urandom_range(0, 255));
                    if (wrong == 8'(nf + 1))
                        wrong = wrong ^ 8'h80;
                    append_byte(wrong);
                    repeat ($urandom_range(0, 4))
                        append_byte(8'($urandom_range(0, 255)));
                end
                else if (pick < 94)
                begin
                    // negative length, then junk to drop
                    nf = $urandom_range(0, 2);
                    add_good_fields(nf);
                    add_field(8'(nf + 1), 32'h8000_0000 | 32'($urandom()), 0);
                    repeat ($urandom_range(0, 4))
                        append_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    // plain noise
                    repeat ($urandom_range(1, 6))
                        append_byte(8'($urandom_range(0, 255)));
                end
            end
            send_msg();
        end
        body_ch.valid <= 1'b0;

        // drain the results still owed, then allow for latency
        while (backlog != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
